// File: rtl/tdpe_pkg.sv
`default_nettype none
package tdpe_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] instruction;
    logic [3:0]  reg_index;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        dest_written;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_carry;
    logic        flag_overflow;
    logic        thumb_mode;
    logic        branch_taken;
  } out_item_t;

  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [2:0] {
    CLS_NOP, CLS_WRITE, CLS_READ, CLS_SHIFT, CLS_ADDSUB, CLS_IMM8, CLS_ALU, CLS_HI
  } cls_t;

  // shifter kinds
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // 8-bit immediate operations
  localparam logic [1:0] IMM_MOV = 2'd0;
  localparam logic [1:0] IMM_CMP = 2'd1;
  localparam logic [1:0] IMM_ADD = 2'd2;
  localparam logic [1:0] IMM_SUB = 2'd3;

  // two-register ALU operations
  localparam logic [3:0] ALU_AND = 4'h0;
  localparam logic [3:0] ALU_EOR = 4'h1;
  localparam logic [3:0] ALU_LSL = 4'h2;
  localparam logic [3:0] ALU_LSR = 4'h3;
  localparam logic [3:0] ALU_ASR = 4'h4;
  localparam logic [3:0] ALU_ADC = 4'h5;
  localparam logic [3:0] ALU_SBC = 4'h6;
  localparam logic [3:0] ALU_ROR = 4'h7;
  localparam logic [3:0] ALU_TST = 4'h8;
  localparam logic [3:0] ALU_NEG = 4'h9;
  localparam logic [3:0] ALU_CMP = 4'hA;
  localparam logic [3:0] ALU_CMN = 4'hB;
  localparam logic [3:0] ALU_ORR = 4'hC;
  localparam logic [3:0] ALU_MUL = 4'hD;
  localparam logic [3:0] ALU_BIC = 4'hE;
  localparam logic [3:0] ALU_MVN = 4'hF;

  // high-register operations
  localparam logic [1:0] HI_ADD = 2'd0;
  localparam logic [1:0] HI_CMP = 2'd1;
  localparam logic [1:0] HI_MOV = 2'd2;
  localparam logic [1:0] HI_BX  = 2'd3;

  localparam logic [3:0] REG_PC = 4'd15;

  // decoded item passed from front to back
  typedef struct packed {
    cls_t        cls;
    logic [3:0]  op;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [3:0]  rd;
    logic [7:0]  imm;
    logic [31:0] wdata;
  } dec_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
    logic t;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{n: 1'b0, z: 1'b0, c: 1'b0, v: 1'b0, t: 1'b1};

endpackage
`default_nettype wire

// File: rtl/tdpe_ram.sv
`default_nettype none
module tdpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/tdpe_front.sv
`default_nettype none
module tdpe_front import tdpe_pkg::*; (
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          in_stall,
  output logic          push,
  output dec_t          push_item
);
  logic [15:0] w;

  assign w        = in_data.instruction;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the transaction and pull out register numbers
  always_comb begin
    push_item       = '0;
    push_item.cls   = CLS_NOP;
    push_item.wdata = in_data.write_value;
    unique case (in_data.action)
      ACT_WRITE: begin
        push_item.cls = CLS_WRITE;
        push_item.rd  = in_data.reg_index;
      end
      ACT_READ: begin
        push_item.cls = CLS_READ;
        push_item.ra  = in_data.reg_index;
      end
      ACT_EXEC: begin
        priority if (w[15:13] == 3'b000 && w[12:11] != 2'b11) begin
          push_item.cls = CLS_SHIFT;
          push_item.op  = {2'b00, w[12:11]};
          push_item.ra  = {1'b0, w[5:3]};
          push_item.rd  = {1'b0, w[2:0]};
          push_item.imm = {3'b000, w[10:6]};
        end else if (w[15:11] == 5'b00011) begin
          push_item.cls = CLS_ADDSUB;
          push_item.op  = {2'b00, w[10], w[9]};
          push_item.ra  = {1'b0, w[5:3]};
          push_item.rb  = {1'b0, w[8:6]};
          push_item.rd  = {1'b0, w[2:0]};
          push_item.imm = {5'b00000, w[8:6]};
        end else if (w[15:13] == 3'b001) begin
          push_item.cls = CLS_IMM8;
          push_item.op  = {2'b00, w[12:11]};
          push_item.ra  = {1'b0, w[10:8]};
          push_item.rd  = {1'b0, w[10:8]};
          push_item.imm = w[7:0];
        end else if (w[15:10] == 6'b010000) begin
          push_item.cls = CLS_ALU;
          push_item.op  = w[9:6];
          push_item.ra  = {1'b0, w[2:0]};
          push_item.rb  = {1'b0, w[5:3]};
          push_item.rd  = {1'b0, w[2:0]};
        end else if (w[15:10] == 6'b010001) begin
          push_item.cls = CLS_HI;
          push_item.op  = {2'b00, w[9:8]};
          push_item.ra  = {w[7], w[2:0]};
          push_item.rb  = {w[6], w[5:3]};
          push_item.rd  = {w[7], w[2:0]};
        end else begin
          push_item.cls = CLS_NOP;
        end
      end
      default: push_item.cls = CLS_NOP;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/tdpe_queue.sv
`default_nettype none
module tdpe_queue import tdpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire dec_t push_item,
  input  wire logic pop,
  output dec_t      head,
  output logic      empty,
  output logic      full
);
  dec_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign head  = entry[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      entry[wptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue lost an entry");
endmodule
`default_nettype wire

// File: rtl/tdpe_back.sv
`default_nettype none
module tdpe_back import tdpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire dec_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);
  dec_t        a_item;
  logic        a_valid;
  logic        a_adv;
  logic        b_fire;
  logic [3:0]  raddr_a;
  logic [3:0]  raddr_b;
  logic [31:0] ram_a;
  logic [31:0] ram_b;
  logic [15:0] written;
  logic        vld_a;
  logic        vld_b;
  logic        byp_a;
  logic        byp_b;
  logic [31:0] byp_val;
  logic [31:0] opa;
  logic [31:0] opb;
  flags_t      flags;
  flags_t      flags_next;
  logic        we;
  logic        ex_we;
  logic        dw;
  logic [3:0]  widx;
  logic [31:0] wval;
  logic [31:0] r;
  logic [31:0] rv;
  logic [31:0] ha;
  logic [31:0] hb;
  logic [7:0]  shamt;
  logic [32:0] sh;
  logic [33:0] sum;
  logic        logic_op;
  logic        store;
  out_item_t   res;

  function automatic logic [32:0] shift_op(input logic [1:0] kind, input logic [31:0] v,
                                           input logic [7:0] n, input logic cin);
    logic [63:0] ext;
    logic [31:0] rot;
    logic [32:0] o;
    begin
      ext = '0;
      rot = '0;
      o   = {cin, v};
      if (n != 8'd0) begin
        unique case (kind)
          SH_LSL: begin
            ext = {32'd0, v} << n;
            o   = {ext[32], ext[31:0]};
          end
          SH_LSR: begin
            ext = {v, 32'd0} >> n;
            o   = {ext[31], ext[63:32]};
          end
          SH_ASR: begin
            ext = $unsigned($signed({v, 32'd0}) >>> n);
            o   = {ext[31], ext[63:32]};
          end
          SH_ROR: begin
            ext = {v, v} >> n[4:0];
            rot = ext[31:0];
            o   = {rot[31], rot};
          end
          default: o = {cin, v};
        endcase
      end
      return o;
    end
  endfunction

  // returns {overflow, carry, sum}
  function automatic logic [33:0] add_op(input logic [31:0] a, input logic [31:0] b,
                                         input logic cin);
    logic [32:0] s;
    begin
      s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      return {(~(a[31] ^ b[31])) & (a[31] ^ s[31]), s};
    end
  endfunction

  assign b_fire  = a_valid && (!out_valid || !out_stall);
  assign a_adv   = !a_valid || b_fire;
  assign q_pop   = a_adv && !q_empty;
  assign raddr_a = a_adv ? q_head.ra : a_item.ra;
  assign raddr_b = a_adv ? q_head.rb : a_item.rb;
  assign we      = b_fire && ex_we;

  tdpe_ram #(.WIDTH(32), .DEPTH(16)) u_ram_a (
    .clk(clk), .we(we), .waddr(widx), .wdata(wval), .raddr(raddr_a), .rdata(ram_a)
  );
  tdpe_ram #(.WIDTH(32), .DEPTH(16)) u_ram_b (
    .clk(clk), .we(we), .waddr(widx), .wdata(wval), .raddr(raddr_b), .rdata(ram_b)
  );

  // forward a write that lands on the same edge as the read
  assign opa = byp_a ? byp_val : (vld_a ? ram_a : 32'd0);
  assign opb = byp_b ? byp_val : (vld_b ? ram_b : 32'd0);
  assign ha  = (a_item.ra == REG_PC) ? opa + 32'd2 : opa;
  assign hb  = (a_item.rb == REG_PC) ? opb + 32'd2 : opb;

  always_comb begin
    flags_next = flags;
    ex_we      = 1'b0;
    dw         = 1'b0;
    widx       = a_item.rd;
    r          = '0;
    rv         = '0;
    shamt      = '0;
    sh         = '0;
    sum        = '0;
    logic_op   = 1'b0;
    store      = 1'b1;
    unique case (a_item.cls)
      CLS_WRITE: begin
        ex_we = 1'b1;
      end
      CLS_READ: begin
        rv = opa;
      end
      CLS_SHIFT: begin
        shamt = a_item.imm;
        if (a_item.imm == 8'd0 && (a_item.op[1:0] == SH_LSR || a_item.op[1:0] == SH_ASR)) begin
          shamt = 8'd32;
        end
        sh           = shift_op(a_item.op[1:0], opa, shamt, flags.c);
        r            = sh[31:0];
        dw           = 1'b1;
        flags_next.c = sh[32];
        flags_next.n = r[31];
        flags_next.z = (r == 32'd0);
      end
      CLS_ADDSUB: begin
        opb_sel_blk: begin
          logic [31:0] bval;
          bval = a_item.op[1] ? {24'd0, a_item.imm} : opb;
          sum  = a_item.op[0] ? add_op(opa, ~bval, 1'b1) : add_op(opa, bval, 1'b0);
        end
        r            = sum[31:0];
        dw           = 1'b1;
        flags_next.n = r[31];
        flags_next.z = (r == 32'd0);
        flags_next.c = sum[32];
        flags_next.v = sum[33];
      end
      CLS_IMM8: begin
        unique case (a_item.op[1:0])
          IMM_MOV: sum = {2'b00, 24'd0, a_item.imm};
          IMM_ADD: sum = add_op(opa, {24'd0, a_item.imm}, 1'b0);
          default: sum = add_op(opa, ~{24'd0, a_item.imm}, 1'b1);
        endcase
        r            = sum[31:0];
        dw           = (a_item.op[1:0] != IMM_CMP);
        flags_next.n = r[31];
        flags_next.z = (r == 32'd0);
        if (a_item.op[1:0] != IMM_MOV) begin
          flags_next.c = sum[32];
          flags_next.v = sum[33];
        end
      end
      CLS_ALU: begin
        sum = {flags.v, flags.c, 32'd0};
        unique case (a_item.op)
          ALU_AND: begin r = opa & opb; logic_op = 1'b1; end
          ALU_EOR: begin r = opa ^ opb; logic_op = 1'b1; end
          ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
            unique case (a_item.op)
              ALU_LSL: sh = shift_op(SH_LSL, opa, opb[7:0], flags.c);
              ALU_LSR: sh = shift_op(SH_LSR, opa, opb[7:0], flags.c);
              ALU_ASR: sh = shift_op(SH_ASR, opa, opb[7:0], flags.c);
              default: sh = shift_op(SH_ROR, opa, opb[7:0], flags.c);
            endcase
            r   = sh[31:0];
            sum = {flags.v, sh[32], 32'd0};
          end
          ALU_ADC: begin sum = add_op(opa, opb, flags.c);   r = sum[31:0]; end
          ALU_SBC: begin sum = add_op(opa, ~opb, flags.c);  r = sum[31:0]; end
          ALU_TST: begin r = opa & opb; logic_op = 1'b1; store = 1'b0; end
          ALU_NEG: begin sum = add_op(32'd0, ~opb, 1'b1); r = sum[31:0]; end
          ALU_CMP: begin sum = add_op(opa, ~opb, 1'b1); r = sum[31:0]; store = 1'b0; end
          ALU_CMN: begin sum = add_op(opa, opb, 1'b0);  r = sum[31:0]; store = 1'b0; end
          ALU_ORR: begin r = opa | opb;  logic_op = 1'b1; end
          ALU_MUL: begin r = opa * opb;  logic_op = 1'b1; end
          ALU_BIC: begin r = opa & ~opb; logic_op = 1'b1; end
          default: begin r = ~opb;       logic_op = 1'b1; end
        endcase
        dw           = store;
        flags_next.n = r[31];
        flags_next.z = (r == 32'd0);
        if (!logic_op) begin
          flags_next.c = sum[32];
          flags_next.v = sum[33];
        end
      end
      CLS_HI: begin
        unique case (a_item.op[1:0])
          HI_ADD: begin
            r  = ha + hb;
            dw = 1'b1;
            if (a_item.rd == REG_PC) begin
              r[0] = 1'b0;
            end
          end
          HI_MOV: begin
            r  = hb;
            dw = 1'b1;
            if (a_item.rd == REG_PC) begin
              r[0] = 1'b0;
            end
          end
          HI_CMP: begin
            sum          = add_op(ha, ~hb, 1'b1);
            r            = sum[31:0];
            flags_next.n = r[31];
            flags_next.z = (r == 32'd0);
            flags_next.c = sum[32];
            flags_next.v = sum[33];
          end
          default: begin
            flags_next.t = hb[0];
            r            = {hb[31:1], 1'b0};
            widx         = REG_PC;
            dw           = 1'b1;
          end
        endcase
      end
      default: begin
        dw = 1'b0;
      end
    endcase
    if (dw) begin
      ex_we = 1'b1;
    end
  end

  assign wval = (a_item.cls == CLS_WRITE) ? a_item.wdata : r;

  always_comb begin
    res               = '0;
    res.read_value    = rv;
    res.dest_written  = dw;
    res.dest_index    = dw ? widx : 4'd0;
    res.dest_value    = dw ? r : 32'd0;
    res.flag_negative = flags_next.n;
    res.flag_zero     = flags_next.z;
    res.flag_carry    = flags_next.c;
    res.flag_overflow = flags_next.v;
    res.thumb_mode    = flags_next.t;
    res.branch_taken  = dw && (widx == REG_PC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      written   <= '0;
      flags     <= FLAGS_RESET;
    end else begin
      if (a_adv) begin
        a_valid <= !q_empty;
      end
      out_valid <= b_fire || (out_valid && out_stall);
      if (we) begin
        written[widx] <= 1'b1;
      end
      if (b_fire) begin
        flags <= flags_next;
      end
    end
    if (q_pop) begin
      a_item <= q_head;
    end
    if (b_fire) begin
      out_data <= res;
    end
    byp_a   <= we && (widx == raddr_a);
    byp_b   <= we && (widx == raddr_b);
    byp_val <= wval;
    vld_a   <= written[raddr_a];
    vld_b   <= written[raddr_b];
  end

  a_branch_dest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.branch_taken) |->
      (out_data.dest_written && out_data.dest_index == REG_PC))
    else $error("branch flagged without a pc write");
  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (b_fire && a_item.cls == CLS_READ) |-> !we)
    else $error("read transaction wrote the register file");
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !b_fire |=> $stable(flags))
    else $error("flags changed without an executed transaction");
  a_reset_flags: assert property (@(posedge clk) $past(rst) |-> flags == FLAGS_RESET)
    else $error("flags not at reset value");
endmodule
`default_nettype wire

// File: rtl/thumb_data_processing_execute_top.sv
`default_nettype none
// Thumb data-processing execute block.
// Input channel: in_valid / in_stall with payload in_data (action, instruction,
// reg_index, write_value). A transaction is taken at a clock edge with in_valid
// high and in_stall low. Output channel: out_valid / out_stall with payload
// out_data; every input transaction yields exactly one output transaction.
// Action execute runs one instruction; write loads a register; read returns a
// register's stored value without touching the flags.
// When nothing stalls, an accepted transaction is written decoded into a
// two-entry queue, then moves into execute with its register-file read, then
// is loaded into the output register. Throughput: one transaction per cycle
// while the receiver does not stall, set by the single execute stage that
// reads and updates the register file and flags each cycle; writes are
// forwarded to the following instruction's operand read.
// Reset (rst, synchronous): registers read as zero, N Z C V clear, T set,
// queue and pipeline empty. No clearing pass is needed.
// When the receiver stalls, the output register holds its transaction, the
// execute stage holds, and the queue fills; in_stall rises once the queue is
// full and drops as soon as an entry drains.
module thumb_data_processing_execute_top import tdpe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  logic push;
  dec_t push_item;
  logic q_pop;
  dec_t q_head;
  logic q_empty;
  logic q_full;

  // classify incoming transactions
  tdpe_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_item(push_item)
  );

  // decouple decode from execute
  tdpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // read operands, execute, update state, drive the result
  tdpe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );
endmodule
`default_nettype wire

// File: test/tdpe_checker.sv
`default_nettype none
module tdpe_checker import tdpe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] regs [16];
  flags_t      fl;
  out_item_t   want_q[$];

  assign pending = want_q.size();

  function automatic logic [31:0] shift_val(input logic [1:0] kind, input logic [31:0] v,
                                            input logic [7:0] amt, input logic is_imm,
                                            inout logic cy);
    int unsigned n;
    int unsigned r;
    n = amt;
    if (n == 0) begin
      if (!is_imm || kind == SH_LSL || kind == SH_ROR) return v;
      n = 32;
    end
    case (kind)
      SH_LSL: begin
        if (n < 32) begin cy = v[32-n]; return v << n; end
        cy = (n == 32) ? v[0] : 1'b0;
        return '0;
      end
      SH_LSR: begin
        if (n < 32) begin cy = v[n-1]; return v >> n; end
        cy = (n == 32) ? v[31] : 1'b0;
        return '0;
      end
      SH_ASR: begin
        if (n < 32) begin cy = v[n-1]; return $signed(v) >>> n; end
        cy = v[31];
        return {32{v[31]}};
      end
      default: begin
        r = n & 31;
        if (r == 0) begin cy = v[31]; return v; end
        cy = v[r-1];
        return (v >> r) | (v << (32 - r));
      end
    endcase
  endfunction

  function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin, output logic cy,
                                            output logic ov);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cy = s[32];
    ov = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
    return s[31:0];
  endfunction

  function automatic logic [31:0] hi_operand(input logic [3:0] i);
    return (i == REG_PC) ? regs[15] + 32'd2 : regs[i];
  endfunction

  // Advance the architectural state by one transaction and build its result.
  function automatic out_item_t execute_item(input in_item_t it);
    out_item_t o;
    logic [15:0] w;
    logic c, v, wr, logic_op, keep;
    logic [31:0] r, a, b;
    logic [3:0] rd, rs;
    logic [1:0] op2;
    logic [3:0] op4;
    o = '0; w = it.instruction; c = fl.c; v = fl.v; wr = 0; r = '0; rd = '0;
    if (it.action == ACT_WRITE) begin
      regs[it.reg_index] = it.write_value;
    end else if (it.action == ACT_READ) begin
      o.read_value = regs[it.reg_index];
    end else if (it.action == ACT_EXEC) begin
      if (w[15:13] == 3'b000 && w[12:11] != 2'b11) begin
        rd = {1'b0, w[2:0]};
        r = shift_val(w[12:11], regs[w[5:3]], {3'b0, w[10:6]}, 1'b1, c);
        wr = 1; fl.n = r[31]; fl.z = (r == 0); fl.c = c;
      end else if (w[15:11] == 5'b00011) begin
        rd = {1'b0, w[2:0]};
        a = regs[w[5:3]];
        b = w[10] ? {29'd0, w[8:6]} : regs[w[8:6]];
        r = w[9] ? add_carry(a, ~b, 1'b1, c, v) : add_carry(a, b, 1'b0, c, v);
        wr = 1; fl.n = r[31]; fl.z = (r == 0); fl.c = c; fl.v = v;
      end else if (w[15:13] == 3'b001) begin
        op2 = w[12:11]; rd = {1'b0, w[10:8]}; a = regs[rd];
        if (op2 == IMM_MOV) r = {24'd0, w[7:0]};
        else if (op2 == IMM_ADD) r = add_carry(a, {24'd0, w[7:0]}, 1'b0, c, v);
        else r = add_carry(a, ~{24'd0, w[7:0]}, 1'b1, c, v);
        wr = (op2 != IMM_CMP);
        fl.n = r[31]; fl.z = (r == 0);
        if (op2 != IMM_MOV) begin fl.c = c; fl.v = v; end
      end else if (w[15:10] == 6'b010000) begin
        op4 = w[9:6]; rd = {1'b0, w[2:0]}; a = regs[rd]; b = regs[w[5:3]];
        keep = 1; logic_op = 0;
        case (op4)
          ALU_AND: begin r = a & b; logic_op = 1; end
          ALU_EOR: begin r = a ^ b; logic_op = 1; end
          ALU_LSL: r = shift_val(SH_LSL, a, b[7:0], 1'b0, c);
          ALU_LSR: r = shift_val(SH_LSR, a, b[7:0], 1'b0, c);
          ALU_ASR: r = shift_val(SH_ASR, a, b[7:0], 1'b0, c);
          ALU_ADC: r = add_carry(a, b, fl.c, c, v);
          ALU_SBC: r = add_carry(a, ~b, fl.c, c, v);
          ALU_ROR: r = shift_val(SH_ROR, a, b[7:0], 1'b0, c);
          ALU_TST: begin r = a & b; logic_op = 1; keep = 0; end
          ALU_NEG: r = add_carry(32'd0, ~b, 1'b1, c, v);
          ALU_CMP: begin r = add_carry(a, ~b, 1'b1, c, v); keep = 0; end
          ALU_CMN: begin r = add_carry(a, b, 1'b0, c, v); keep = 0; end
          ALU_ORR: begin r = a | b; logic_op = 1; end
          ALU_MUL: begin r = a * b; logic_op = 1; end
          ALU_BIC: begin r = a & ~b; logic_op = 1; end
          default: begin r = ~b; logic_op = 1; end
        endcase
        wr = keep; fl.n = r[31]; fl.z = (r == 0);
        if (!logic_op) begin fl.c = c; fl.v = v; end
      end else if (w[15:10] == 6'b010001) begin
        op2 = w[9:8]; rs = {w[6], w[5:3]}; rd = {w[7], w[2:0]};
        b = hi_operand(rs);
        if (op2 == HI_ADD || op2 == HI_MOV) begin
          r = (op2 == HI_ADD) ? hi_operand(rd) + b : b;
          if (rd == REG_PC) r[0] = 1'b0;
          wr = 1;
        end else if (op2 == HI_CMP) begin
          r = add_carry(hi_operand(rd), ~b, 1'b1, c, v);
          fl.n = r[31]; fl.z = (r == 0); fl.c = c; fl.v = v;
          rd = '0;
        end else begin
          fl.t = b[0]; r = {b[31:1], 1'b0}; rd = REG_PC; wr = 1;
        end
      end
      if (wr) regs[rd] = r;
    end
    o.dest_written  = wr;
    o.dest_index    = wr ? rd : 4'd0;
    o.dest_value    = wr ? r : 32'd0;
    o.flag_negative = fl.n;
    o.flag_zero     = fl.z;
    o.flag_carry    = fl.c;
    o.flag_overflow = fl.v;
    o.thumb_mode    = fl.t;
    o.branch_taken  = wr && rd == REG_PC;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      fl = FLAGS_RESET;
      want_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) want_q.push_back(execute_item(in_data));
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: exp rv=%h dw=%b di=%0d dv=%h nzcvt=%b%b%b%b%b bt=%b | act rv=%h dw=%b di=%0d dv=%h nzcvt=%b%b%b%b%b bt=%b",
                       want.read_value, want.dest_written, want.dest_index, want.dest_value,
                       want.flag_negative, want.flag_zero, want.flag_carry, want.flag_overflow,
                       want.thumb_mode, want.branch_taken,
                       out_data.read_value, out_data.dest_written, out_data.dest_index,
                       out_data.dest_value, out_data.flag_negative, out_data.flag_zero,
                       out_data.flag_carry, out_data.flag_overflow, out_data.thumb_mode,
                       out_data.branch_taken);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top import tdpe_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk, rst;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending;
  int        cycles;
  int        idle_pct, stall_pct;

  thumb_data_processing_execute_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tdpe_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("[thumb_data_processing_execute_top] ERROR");
        $finish;
      end
    end
  end

  // Receiver: stall at random with the current phase's odds.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Present one transaction, holding it until taken; idle gaps come before it.
  // Valid stays high after the handshake; drop it before waiting on the block.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid; it stays low until the next send.
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t exec_item(input logic [15:0] w);
    in_item_t it;
    it = '0; it.action = ACT_EXEC; it.instruction = w;
    it.reg_index = 4'($urandom); it.write_value = $urandom;
    return it;
  endfunction

  function automatic in_item_t wr_item(input logic [3:0] r, input logic [31:0] v);
    in_item_t it;
    it = '0; it.action = ACT_WRITE; it.reg_index = r; it.write_value = v;
    it.instruction = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t rd_item(input logic [3:0] r);
    in_item_t it;
    it = '0; it.action = ACT_READ; it.reg_index = r; it.instruction = 16'($urandom);
    return it;
  endfunction

  // Build a random instruction word, mostly from the five data-processing formats.
  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(11))
      0, 1:  w[15:13] = 3'b000;
      2:     w[15:11] = 5'b00011;
      3, 4:  w[15:13] = 3'b001;
      5, 6, 7: w[15:10] = 6'b010000;
      8, 9:  w[15:10] = 6'b010001;
      default: ;
    endcase
    return w;
  endfunction

  // Pick a register value with a bias toward edges.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    in_item_t it;
    idle_pct = idle; stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: it = wr_item(4'($urandom), rand_val());
        2:    it = rd_item(4'($urandom));
        3: begin
          it = exec_item(16'($urandom));
          it.action = 2'd3;
        end
        default: it = exec_item(rand_word());
      endcase
      send(it);
    end
  endtask

  initial begin
    in_valid = 0; in_data = '0; out_stall = 0; idle_pct = 0; stall_pct = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: edge operands, every format, all immediate, ALU and hi-register ops, PC reads and BX.
    send(wr_item(4'd0, 32'hFFFF_FFFF));
    send(wr_item(4'd1, 32'h8000_0001));
    send(wr_item(4'd15, 32'h0000_1001));
    send(exec_item(16'b000_00_00000_001_010));   // LSL #0 keeps carry
    send(exec_item(16'b000_01_00000_001_011));   // LSR #0 means 32
    send(exec_item(16'b000_10_00000_001_100));   // ASR #0 means 32
    send(exec_item(16'b000_00_11111_000_101));   // LSL #31
    send(exec_item(16'b00011_1_0_111_000_110));  // ADD #7
    send(exec_item(16'b00011_0_1_001_000_111));  // SUB reg
    for (int op = 0; op < 4; op++) send(exec_item({3'b001, 2'(op), 3'd0, 8'hFF}));
    for (int op = 0; op < 16; op++) send(exec_item({6'b010000, 4'(op), 3'd1, 3'd0}));
    send(exec_item({6'b010001, HI_ADD, 1'b1, 1'b1, 3'd7, 3'd7}));  // ADD pc,pc
    send(exec_item({6'b010001, HI_CMP, 1'b1, 1'b0, 3'd0, 3'd7}));
    send(exec_item({6'b010001, HI_MOV, 1'b0, 1'b1, 3'd7, 3'd1}));
    send(wr_item(4'd9, 32'h0000_0101));
    send(exec_item({6'b010001, HI_BX, 1'b1, 1'b1, 3'd1, 3'd0}));   // BX odd
    send(exec_item({6'b010001, HI_BX, 1'b0, 1'b1, 3'd7, 3'd0}));   // BX pc
    send(rd_item(4'd15));

    // Random phases under varying pressure.
    random_phase(400, 0, 0);
    random_phase(300, 58, 0);
    // Hold off the sender until everything has drained.
    drop_valid();
    while (pending != 0) @(negedge clk);
    random_phase(400, 0, 58);
    random_phase(400, 15, 15);

    drop_valid();
    idle_pct = 0; stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("[thumb_data_processing_execute_top] OK");
    else $display("[thumb_data_processing_execute_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// File: thumb_data_processing_execute_top.f
rtl/tdpe_pkg.sv
rtl/tdpe_ram.sv
rtl/tdpe_front.sv
rtl/tdpe_queue.sv
rtl/tdpe_back.sv
rtl/thumb_data_processing_execute_top.sv
test/tdpe_checker.sv
test/tb_top.sv
